// ===== rtl/rmq_pkg.sv =====
// Package for the rotation matrix to quaternion converter.
// Holds widths, pivot codes, stage types and the square root step function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rmq_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 30;

  localparam int DW     = DATA_WIDTH;
  localparam int TW     = DW + 2;      // radicand, signed
  localparam int PW     = DW + 1;      // off-diagonal sum or difference, signed
  localparam int NW     = 2 * DW;      // square root and divider numerator width
  localparam int RMW    = DW + 2;      // square root remainder width
  localparam int DRW    = DW + 1;      // divider remainder and denominator width
  localparam int NLANES = 3;

  localparam int IN_TDATA_W  = ((9 * DW + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((4 * DW + 7) / 8) * 8;
  localparam int OUT_TUSER_W = 3;

  localparam logic [1:0] PIV_X = 2'd0;
  localparam logic [1:0] PIV_Y = 2'd1;
  localparam logic [1:0] PIV_Z = 2'd2;

  localparam logic [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

  typedef struct packed {
    logic                               deg;
    logic [1:0]                         pivot;
    logic [NLANES-1:0][PW-1:0]          pair;
  } side_t;

  typedef struct packed {
    logic            vld;
    logic [NW-1:0]   n;
    logic [RMW-1:0]  rem;
    logic [DW-1:0]   q;
    side_t           side;
  } sq_stage_t;

  typedef struct packed {
    logic            deg;
    logic [1:0]      pivot;
    logic [DW-1:0]   root;
  } tag_t;

  typedef struct packed {
    logic                         vld;
    logic [NLANES-1:0][NW-1:0]    num;
    logic [NLANES-1:0][DRW-1:0]   rem;
    logic [NLANES-1:0][DW-1:0]    q;
    logic [NLANES-1:0]            ovf;
    logic [NLANES-1:0]            neg;
    logic [DRW-1:0]               den;
    tag_t                         tag;
  } dv_stage_t;

  // One digit of the restoring square root: two radicand bits in, one root bit out.
  function automatic sq_stage_t sq_step(sq_stage_t a);
    logic [RMW+1:0] r;
    logic [RMW+1:0] tr;
    sq_step = a;
    r  = {a.rem, a.n[NW-1 -: 2]};
    tr = {2'b00, a.q, 2'b01};
    sq_step.n = a.n << 2;
    if (r >= tr) begin
      sq_step.rem = RMW'(r - tr);
      sq_step.q   = {a.q[DW-2:0], 1'b1};
    end else begin
      sq_step.rem = r[RMW-1:0];
      sq_step.q   = {a.q[DW-2:0], 1'b0};
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/rmq_front.sv =====
// Front stage: pivot selection, radicand and off-diagonal pairs.
// Depends on rmq_pkg; feeds rmq_sqrt.
`timescale 1ns / 1ps
`default_nettype none
module rmq_front import rmq_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  valid_i,
  input  wire logic [IN_TDATA_W-1:0] tdata_i,
  output sq_stage_t                  stage_o
);

  localparam logic signed [TW-1:0] ONE = TW'(1) <<< FRAC_BITS;

  logic signed [TW-1:0] e [9];
  logic [1:0]           piv;
  logic signed [TW-1:0] t;
  logic signed [PW-1:0] pa, pb, pw;
  logic                 deg;
  sq_stage_t            stage_d, stage_q;

  for (genvar k = 0; k < 9; k++) begin : g_ext
    assign e[k] = signed'({{2{tdata_i[k*DW+DW-1]}}, tdata_i[k*DW +: DW]});
  end

  // Strict compares; ties fall to the later diagonal entry.
  always_comb begin
    if (e[0] > e[4]) begin
      piv = (e[0] > e[8]) ? PIV_X : PIV_Z;
    end else begin
      piv = (e[4] > e[8]) ? PIV_Y : PIV_Z;
    end
  end

  always_comb begin
    case (piv)
      PIV_X: begin
        t  = ONE + e[0] - e[4] - e[8];
        pa = PW'(e[1] + e[3]);
        pb = PW'(e[6] + e[2]);
        pw = PW'(e[7] - e[5]);
      end
      PIV_Y: begin
        t  = ONE + e[4] - e[8] - e[0];
        pa = PW'(e[1] + e[3]);
        pb = PW'(e[5] + e[7]);
        pw = PW'(e[2] - e[6]);
      end
      default: begin
        t  = ONE + e[8] - e[0] - e[4];
        pa = PW'(e[6] + e[2]);
        pb = PW'(e[5] + e[7]);
        pw = PW'(e[3] - e[1]);
      end
    endcase
    deg = t[TW-1] || (t == '0);
  end

  always_comb begin
    stage_d                = '0;
    stage_d.vld            = valid_i;
    stage_d.n              = deg ? '0 : ({{(DW-1){1'b0}}, t[DW:0]} << FRAC_BITS);
    stage_d.side.deg       = deg;
    stage_d.side.pivot     = piv;
    stage_d.side.pair[0]   = pa;
    stage_d.side.pair[1]   = pb;
    stage_d.side.pair[2]   = pw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule
`default_nettype wire

// ===== rtl/rmq_sqrt.sv =====
// Pipelined integer square root, one root bit per register stage.
// Depends on rmq_pkg (sq_step); carries the item's side fields along.
`timescale 1ns / 1ps
`default_nettype none
module rmq_sqrt import rmq_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  sq_stage_t stage_i,
  output sq_stage_t stage_o
);

  sq_stage_t st_q [DW+1];

  assign st_q[0] = stage_i;

  for (genvar k = 0; k < DW; k++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_q[k+1] <= '0;
      end else if (en_i) begin
        st_q[k+1] <= sq_step(st_q[k]);
      end
    end
  end

  assign stage_o = st_q[DW];

endmodule
`default_nettype wire

// ===== rtl/rmq_div.sv =====
// Pipelined three-lane restoring divider with a shared denominator.
// Depends on rmq_pkg; first stage checks for quotient overflow.
`timescale 1ns / 1ps
`default_nettype none
module rmq_div import rmq_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  dv_stage_t stage_i,
  output dv_stage_t stage_o
);

  dv_stage_t st_q [DW+1];
  dv_stage_t chk_d;

  // The quotient fits in DW bits only when the upper numerator half is below the divisor.
  always_comb begin
    chk_d = stage_i;
    for (int l = 0; l < NLANES; l++) begin
      chk_d.ovf[l] = {1'b0, stage_i.num[l][NW-1:DW]} >= stage_i.den;
      chk_d.rem[l] = {1'b0, stage_i.num[l][NW-1:DW]};
      chk_d.num[l] = stage_i.num[l] << DW;
      chk_d.q[l]   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q[0] <= '0;
    end else if (en_i) begin
      st_q[0] <= chk_d;
    end
  end

  for (genvar k = 0; k < DW; k++) begin : g_stage
    dv_stage_t nx_d;
    logic [DRW:0] r [NLANES];
    always_comb begin
      nx_d = st_q[k];
      for (int l = 0; l < NLANES; l++) begin
        r[l] = {st_q[k].rem[l], st_q[k].num[l][NW-1]};
        nx_d.num[l] = st_q[k].num[l] << 1;
        if (r[l] >= {1'b0, st_q[k].den}) begin
          nx_d.rem[l] = DRW'(r[l] - {1'b0, st_q[k].den});
          nx_d.q[l]   = {st_q[k].q[l][DW-2:0], 1'b1};
        end else begin
          nx_d.rem[l] = r[l][DRW-1:0];
          nx_d.q[l]   = {st_q[k].q[l][DW-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_q[k+1] <= '0;
      end else if (en_i) begin
        st_q[k+1] <= nx_d;
      end
    end
  end

  assign stage_o = st_q[DW];

endmodule
`default_nettype wire

// ===== rtl/rotation_matrix_to_quaternion.sv =====
// Top level of the rotation matrix to quaternion converter (Shepperd's method).
// Depends on rmq_pkg, rmq_front, rmq_sqrt and rmq_div.
//
// Usage: one item on the slave stream carries the nine Q2.30 entries of a
// 3x3 rotation matrix, m00 in the lowest bits, row by row. One result item
// leaves on the master stream with the quaternion x, y, z, w in tdata and the
// degenerate flag and pivot index in tuser.
// Throughput: one item per cycle unless the receiver stalls the output. The path
// is the front register, the square root (one root bit per stage), the prepare
// register, the overflow check register, the divider (one quotient bit per
// stage) and the output register.
// The whole pipeline advances together: when the receiver holds tready low
// while a result is waiting, every stage holds and s_axis_tready drops; no
// item is lost or repeated. Bubbles still move forward while the output
// register is empty.
// Reset clears every valid bit; the block needs no warm-up after it.
`timescale 1ns / 1ps
`default_nettype none
module rotation_matrix_to_quaternion import rmq_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output      logic                   s_axis_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 from the lowest bit up
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output      logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // quat_x, quat_y, quat_z, quat_w from the lowest bit up
  output      logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // degenerate, pivot[1:0] from the lowest bit up
  output      logic [OUT_TUSER_W-1:0] m_axis_tuser
);

  logic      en;
  sq_stage_t fr_st, sq_st;
  dv_stage_t prep_d, prep_q, dv_st;

  logic                 out_vld_q;
  logic [DW-1:0]        qx_q, qy_q, qz_q, qw_q;
  logic                 deg_q;
  logic [1:0]           piv_q;
  logic [DW-1:0]        lane_v [NLANES];
  logic [DW-1:0]        qx_d, qy_d, qz_d, qw_d;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  rmq_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .tdata_i (s_axis_tdata),
    .stage_o (fr_st)
  );

  rmq_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .stage_i (fr_st),
    .stage_o (sq_st)
  );

  // Numerator is |pair| * 2^FRAC_BITS plus half the divisor, for round to nearest.
  always_comb begin
    logic [PW-1:0] mag;
    prep_d          = '0;
    prep_d.vld      = sq_st.vld;
    prep_d.den      = {sq_st.q, 1'b0};
    prep_d.tag.deg  = sq_st.side.deg;
    prep_d.tag.pivot = sq_st.side.pivot;
    prep_d.tag.root = sq_st.q >> 1;
    for (int l = 0; l < NLANES; l++) begin
      prep_d.neg[l] = sq_st.side.pair[l][PW-1];
      mag = sq_st.side.pair[l][PW-1] ? PW'(-sq_st.side.pair[l]) : sq_st.side.pair[l];
      prep_d.num[l] = (NW'(mag) << FRAC_BITS) + NW'(sq_st.q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_q <= '0;
    end else if (en) begin
      prep_q <= prep_d;
    end
  end

  rmq_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .stage_i (prep_q),
    .stage_o (dv_st)
  );

  always_comb begin
    for (int l = 0; l < NLANES; l++) begin
      if (dv_st.neg[l]) begin
        lane_v[l] = (dv_st.ovf[l] || dv_st.q[l][DW-1]) ? SAT_MIN : DW'(-dv_st.q[l]);
      end else begin
        lane_v[l] = (dv_st.ovf[l] || dv_st.q[l][DW-1]) ? SAT_MAX : dv_st.q[l];
      end
    end
    case (dv_st.tag.pivot)
      PIV_X: begin
        qx_d = dv_st.tag.root; qy_d = lane_v[0]; qz_d = lane_v[1];
      end
      PIV_Y: begin
        qx_d = lane_v[0]; qy_d = dv_st.tag.root; qz_d = lane_v[1];
      end
      default: begin
        qx_d = lane_v[0]; qy_d = lane_v[1]; qz_d = dv_st.tag.root;
      end
    endcase
    qw_d = lane_v[2];
    if (dv_st.tag.deg) begin
      qx_d = '0; qy_d = '0; qz_d = '0; qw_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_st.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      qx_q  <= qx_d;
      qy_q  <= qy_d;
      qz_q  <= qz_d;
      qw_q  <= qw_d;
      deg_q <= dv_st.tag.deg;
      piv_q <= dv_st.tag.pivot;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_TDATA_W'({qw_q, qz_q, qy_q, qx_q});
  assign m_axis_tuser  = {piv_q, deg_q};

endmodule
`default_nettype wire
